// ===== src/kvt_pkg.sv =====
package kvt_pkg;

  // Field widths of the item channels
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } kvt_op_t;

  // Control bits of the search token that walks the cell row
  typedef struct packed {
    logic valid;
    logic found;
    logic is_del;
  } kvt_tok_t;

  // Write strobes broadcast to every cell
  typedef struct packed {
    logic append;
    logic swap;
  } kvt_wr_t;

endpackage

// ===== src/kvt_stream_if.sv =====
interface kvt_in_if;
  import kvt_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface kvt_out_if;
  import kvt_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [VALUE_W-1:0] value_out;
  logic [COUNT_W-1:0] entry_count;
  logic               put_dropped;

  modport source (output valid, output found, output value_out, output entry_count,
                  output put_dropped, input ready);
  modport sink   (input valid, input found, input value_out, input entry_count,
                  input put_dropped, output ready);
endinterface

// ===== src/kvt_cell.sv =====
module kvt_cell #(
  parameter int DEPTH      = 32,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int IDX        = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kvt_pkg::kvt_tok_t                   tok_i,
  input  logic [KEY_BITS-1:0]                 tkey_i,
  input  logic [VALUE_BITS-1:0]               tval_i,
  input  logic [KEY_BITS-1:0]                 tlkey_i,
  input  logic [VALUE_BITS-1:0]               tlval_i,
  output kvt_pkg::kvt_tok_t                   tok_o,
  output logic [KEY_BITS-1:0]                 tkey_o,
  output logic [VALUE_BITS-1:0]               tval_o,
  output logic [KEY_BITS-1:0]                 tlkey_o,
  output logic [VALUE_BITS-1:0]               tlval_o,
  input  logic [$clog2(DEPTH+1)-1:0]          cnt_i,
  input  kvt_pkg::kvt_wr_t                    wr_i,
  input  logic [KEY_BITS-1:0]                 wr_key_i,
  input  logic [VALUE_BITS-1:0]               wr_val_i
);
  import kvt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  victim_r, victim_nxt;
  kvt_tok_t              tok_r, tok_nxt;
  logic [KEY_BITS-1:0]   tkey_r, tkey_nxt;
  logic [VALUE_BITS-1:0] tval_r, tval_nxt;
  logic [KEY_BITS-1:0]   tlkey_r, tlkey_nxt;
  logic [VALUE_BITS-1:0] tlval_r, tlval_nxt;
  logic                  hit;
  logic                  is_last;

  // Compare the passing key with this slot when the slot is occupied
  assign hit     = tok_i.valid && !tok_i.found && (IDX_C < cnt_i) && (key_r == tkey_i);
  assign is_last = (IDX_P1 == cnt_i);

  // Hand the token on, picking up the match and the last entry on the way
  always_comb begin
    tok_nxt       = tok_i;
    tok_nxt.found = tok_i.found || hit;
    tkey_nxt      = tkey_i;
    tval_nxt      = hit ? val_r : tval_i;
    tlkey_nxt     = (tok_i.valid && is_last) ? key_r : tlkey_i;
    tlval_nxt     = (tok_i.valid && is_last) ? val_r : tlval_i;
  end

  // Load the slot on an append at the count or on the delete swap
  always_comb begin
    key_nxt    = key_r;
    val_nxt    = val_r;
    victim_nxt = victim_r;
    if (tok_i.valid) begin
      victim_nxt = hit && tok_i.is_del;
    end else if (wr_i.swap) begin
      victim_nxt = 1'b0;
    end
    if ((wr_i.append && (IDX_C == cnt_i)) || (wr_i.swap && victim_r)) begin
      key_nxt = wr_key_i;
      val_nxt = wr_val_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= '0;
      victim_r <= 1'b0;
    end else begin
      tok_r    <= tok_nxt;
      victim_r <= victim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    tkey_r  <= tkey_nxt;
    tval_r  <= tval_nxt;
    tlkey_r <= tlkey_nxt;
    tlval_r <= tlval_nxt;
  end

  assign tok_o   = tok_r;
  assign tkey_o  = tkey_r;
  assign tval_o  = tval_r;
  assign tlkey_o = tlkey_r;
  assign tlval_o = tlval_r;

endmodule

// ===== src/key_value_table.sv =====
// Channel  Dir  Payload                                      Handshake
// in_if    in   operation, key, value                        valid/ready
// out_if   out  found, value_out, entry_count, put_dropped   valid/ready
//
// A lookup or delete sends the search token through the row of DEPTH cells,
// one cell a cycle, and then finishes the item in ST_DONE.
// A put or an unused code goes straight to ST_DONE. One item is at work at a time.
// Reset (rst_n low, synchronous) empties the table; slot contents are not cleared.
// The next item is taken while a result waits; a stalled result holds the finish.
module key_value_table #(
  parameter int DEPTH      = 32,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input logic      clk,
  input logic      rst_n,
  kvt_in_if.sink   in_if,
  kvt_out_if.source out_if
);
  import kvt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } kvt_state_t;

  kvt_state_t            state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  found_r, found_nxt;
  logic [VALUE_BITS-1:0] vout_r, vout_nxt;
  logic [KEY_BITS-1:0]   lkey_r, lkey_nxt;
  logic [VALUE_BITS-1:0] lval_r, lval_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  ovalid_r, ovalid_nxt;
  logic                  ofound_r, ofound_nxt;
  logic [VALUE_W-1:0]    ovalue_r, ovalue_nxt;
  logic [COUNT_W-1:0]    ocount_r, ocount_nxt;
  logic                  odrop_r, odrop_nxt;

  logic                  accept;
  logic                  finish;
  kvt_wr_t               wr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;

  kvt_tok_t              tok    [DEPTH+1];
  logic [KEY_BITS-1:0]   tkey   [DEPTH+1];
  logic [VALUE_BITS-1:0] tval   [DEPTH+1];
  logic [KEY_BITS-1:0]   tlkey  [DEPTH+1];
  logic [VALUE_BITS-1:0] tlval  [DEPTH+1];

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign finish      = (state_r == ST_DONE) && (!ovalid_r || out_if.ready);

  // Launch the search token into the first cell
  assign tok[0]   = '{valid:  accept && ((in_if.operation == OP_LOOKUP) ||
                                         (in_if.operation == OP_DELETE)),
                      found:  1'b0,
                      is_del: (in_if.operation == OP_DELETE)};
  assign tkey[0]  = KEY_BITS'(in_if.key);
  assign tval[0]  = '0;
  assign tlkey[0] = '0;
  assign tlval[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    kvt_cell #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (tok[i]),
      .tkey_i   (tkey[i]),
      .tval_i   (tval[i]),
      .tlkey_i  (tlkey[i]),
      .tlval_i  (tlval[i]),
      .tok_o    (tok[i+1]),
      .tkey_o   (tkey[i+1]),
      .tval_o   (tval[i+1]),
      .tlkey_o  (tlkey[i+1]),
      .tlval_o  (tlval[i+1]),
      .cnt_i    (count_r),
      .wr_i     (wr),
      .wr_key_i (wr_key),
      .wr_val_i (wr_val)
    );
  end

  // Sequence one item: take it, wait for the token on a lookup or delete, finish
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    found_nxt  = found_r;
    vout_nxt   = vout_r;
    lkey_nxt   = lkey_r;
    lval_nxt   = lval_r;
    count_nxt  = count_r;
    ovalid_nxt = ovalid_r && !out_if.ready;
    ofound_nxt = ofound_r;
    ovalue_nxt = ovalue_r;
    ocount_nxt = ocount_r;
    odrop_nxt  = odrop_r;
    wr         = '0;
    wr_key     = (op_r == OP_PUT) ? key_r : lkey_r;
    wr_val     = (op_r == OP_PUT) ? val_r : lval_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_if.operation;
          key_nxt   = KEY_BITS'(in_if.key);
          val_nxt   = VALUE_BITS'(in_if.value);
          found_nxt = 1'b0;
          vout_nxt  = '0;
          state_nxt = tok[0].valid ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (tok[DEPTH].valid) begin
          found_nxt = tok[DEPTH].found;
          vout_nxt  = tval[DEPTH];
          lkey_nxt  = tlkey[DEPTH];
          lval_nxt  = tlval[DEPTH];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          ofound_nxt = 1'b0;
          ovalue_nxt = '0;
          odrop_nxt  = 1'b0;
          unique case (op_r)
            OP_PUT: begin
              if (count_r == DEPTH_C) begin
                odrop_nxt = 1'b1;
              end else begin
                wr.append = 1'b1;
                count_nxt = count_r + ONE_C;
              end
            end
            OP_LOOKUP: begin
              ofound_nxt = found_r;
              ovalue_nxt = found_r ? VALUE_W'(vout_r) : '0;
            end
            OP_DELETE: begin
              ofound_nxt = found_r;
              if (found_r) begin
                wr.swap   = 1'b1;
                count_nxt = count_r - ONE_C;
              end
            end
            default: begin
            end
          endcase
          ocount_nxt = COUNT_W'(count_nxt);
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    found_r  <= found_nxt;
    vout_r   <= vout_nxt;
    lkey_r   <= lkey_nxt;
    lval_r   <= lval_nxt;
    ofound_r <= ofound_nxt;
    ovalue_r <= ovalue_nxt;
    ocount_r <= ocount_nxt;
    odrop_r  <= odrop_nxt;
  end

  assign out_if.valid       = ovalid_r;
  assign out_if.found       = ofound_r;
  assign out_if.value_out   = ovalue_r;
  assign out_if.entry_count = ocount_r;
  assign out_if.put_dropped = odrop_r;

endmodule

// ===== src/kvt_checker.sv =====
module kvt_checker #(
  parameter int DEPTH = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        found,
  input logic [kvt_pkg::VALUE_W-1:0] value_out,
  input logic [kvt_pkg::COUNT_W-1:0] entry_count,
  input logic                        put_dropped
);
  import kvt_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(value_out)
      && $stable(entry_count) && $stable(put_dropped))
    else $error("stalled result changed");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown after reset");

  // A dropped put never reports a match or a value
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && put_dropped |-> !found && (value_out == '0))
    else $error("dropped put carries match data");

  // A value is only returned on a match
  a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> (value_out == '0))
    else $error("value returned without a match");

  // Count never exceeds the table depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH > 63) || (int'(entry_count) <= DEPTH))
    else $error("entry count beyond depth");

endmodule

bind key_value_table kvt_checker #(.DEPTH(DEPTH)) u_kvt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .found       (out_if.found),
  .value_out   (out_if.value_out),
  .entry_count (out_if.entry_count),
  .put_dropped (out_if.put_dropped)
);

// ===== bench/key_value_table_test.sv =====
module key_value_table_test;
  import kvt_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int POOL_N      = 24;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = TABLE_DEPTH + 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0] entry_count;
    logic               put_dropped;
  } kv_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               typed;
    kv_result_t         want;
  } stim_row_t;

  typedef struct packed {
    logic       typed;
    kv_result_t want;
  } hand_result_t;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_PERIODIC,
    RX_COIN,
    RX_LONG_HOLD
  } rx_mode_t;

  logic clk;
  logic rst_n;

  kvt_in_if  in_ch ();
  kvt_out_if out_ch ();

  key_value_table #(
    .DEPTH     (TABLE_DEPTH),
    .KEY_BITS  (KEY_W),
    .VALUE_BITS(VALUE_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Mirror of the table contents
  logic [KEY_W-1:0]   mirror_keys [TABLE_DEPTH];
  logic [VALUE_W-1:0] mirror_vals [TABLE_DEPTH];
  int                 mirror_count;

  kv_result_t   pending_results [$];
  hand_result_t hand_results [$];
  logic [KEY_W-1:0] key_pool [POOL_N];

  int errors;
  int sent_count;
  int checked_count;
  int quiet_cycles;
  int burst_left;

  // Short directed pass: empty table, extreme keys and values, duplicates, swap on delete
  stim_row_t directed_rows [23] = '{
    '{OP_LOOKUP, 32'h0000_0000, 32'h1234_5678, 1'b1, '{1'b0, 32'h0000_0000, 6'd0, 1'b0}},
    '{OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 6'd0, 1'b0}},
    '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 6'd0, 1'b0}},
    '{OP_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 6'd1, 1'b0}},
    '{OP_PUT,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd2, 1'b0}},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 6'd2, 1'b0}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 6'd2, 1'b0}},
    '{OP_PUT,    32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b0, 32'h0000_0000, 6'd3, 1'b0}},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 6'd3, 1'b0}},
    '{OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd3, 1'b0}},
    '{OP_PUT,    32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0},
    '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd3, 1'b0}},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{OP_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, '0},
    '{OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 6'd2, 1'b0}},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd2, 1'b0}},
    '{OP_DELETE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd2, 1'b0}},
    '{OP_UNUSED, 32'h5A5A_5A5A, 32'h0000_1234, 1'b1, '{1'b0, 32'h0000_0000, 6'd2, 1'b0}},
    '{OP_PUT,    32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, '0},
    '{OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{OP_DELETE, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, '0},
    '{OP_DELETE, 32'h5A5A_5A5A, 32'h0000_0000, 1'b0, '0},
    '{OP_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd0, 1'b0}}
  };

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one operation to the mirror and return the result it yields
  function automatic kv_result_t kv_apply(input logic [OP_W-1:0] op,
                                          input logic [KEY_W-1:0] key,
                                          input logic [VALUE_W-1:0] value);
    kv_result_t r;
    int         hit;
    r   = '0;
    hit = -1;
    if (op == OP_PUT) begin
      if (mirror_count >= TABLE_DEPTH) begin
        r.put_dropped = 1'b1;
      end else begin
        mirror_keys[mirror_count] = key;
        mirror_vals[mirror_count] = value;
        mirror_count++;
      end
    end else if (op == OP_LOOKUP || op == OP_DELETE) begin
      // first match in slot order wins
      for (int i = 0; i < mirror_count; i++)
        if (hit < 0 && mirror_keys[i] == key) hit = i;
      if (hit >= 0) begin
        r.found = 1'b1;
        if (op == OP_LOOKUP) begin
          r.value_out = mirror_vals[hit];
        end else begin
          mirror_keys[hit] = mirror_keys[mirror_count-1];
          mirror_vals[hit] = mirror_vals[mirror_count-1];
          mirror_count--;
        end
      end
    end
    r.entry_count = COUNT_W'(mirror_count);
    return r;
  endfunction

  // Drive one item, wait for its handshake, then idle between bursts
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value, input logic typed,
                           input kv_result_t want);
    hand_results.push_back('{typed, want});
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= key;
    in_ch.value     <= value;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left   = $urandom_range(0, 23);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sent_count > checked_count);
  endtask

  // Build one random item shaped by the kind of phase
  task automatic send_random(input phase_t ph);
    int                 roll;
    int                 put_pct;
    int                 look_pct;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    case (ph)
      PH_FILL:  begin put_pct = 80; look_pct = 12; end
      PH_DRAIN: begin put_pct = 15; look_pct = 25; end
      default:  begin put_pct = 40; look_pct = 35; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < put_pct) op = OP_PUT;
    else if (roll < put_pct + look_pct) op = OP_LOOKUP;
    else if (roll < 98) op = OP_DELETE;
    else op = OP_UNUSED;
    // mostly keys that are stored or reused, a few fresh ones
    roll = $urandom_range(0, 99);
    if (op != OP_PUT && mirror_count > 0 && roll < 70)
      key = mirror_keys[$urandom_range(0, mirror_count - 1)];
    else if (roll < 85)
      key = key_pool[$urandom_range(0, POOL_N - 1)];
    else
      key = $urandom();
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom();
    endcase
    send_item(op, key, value, 1'b0, '0);
  endtask

  // Stimulus
  initial begin
    int     random_sent;
    int     phase_len;
    phase_t ph;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.key       = '0;
    in_ch.value     = '0;
    errors          = 0;
    sent_count      = 0;
    checked_count   = 0;
    mirror_count    = 0;
    burst_left      = $urandom_range(0, 23);
    key_pool[0]     = '0;
    key_pool[1]     = '1;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // Random phases: start by filling past the top so puts get dropped
    random_sent = 0;
    ph          = PH_FILL;
    phase_len   = 60;
    while (random_sent < RANDOM_ITEMS) begin
      repeat (phase_len) begin
        send_random(ph);
        random_sent++;
      end
      if ($urandom_range(0, 2) == 0) drain_results();
      ph        = phase_t'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 120);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("key_value_table verification clean");
    else
      $display("key_value_table verification failed");
    $finish;
  end

  // Receiver: ready on a pattern whose mode is picked anew at random when its run ends
  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       rx_hold;
  int       rx_cycle;

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode      <= RX_OPEN;
      rx_mode_left <= 0;
      rx_hold      <= 0;
      rx_cycle     <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(50, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_PERIODIC: out_ch.ready <= (rx_cycle % 7) >= 2;
        RX_COIN:     out_ch.ready <= $urandom_range(0, 1);
        default: begin
          if (rx_hold != 0) begin
            out_ch.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
          end else if ($urandom_range(0, 3) == 0) begin
            out_ch.ready <= 1'b0;
            rx_hold      <= $urandom_range(1, 16);
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Predict on each accepted item, compare each accepted result, watch for a hang
  always @(posedge clk) begin
    kv_result_t   got;
    kv_result_t   want;
    hand_result_t hand;
    logic         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        hand  = (hand_results.size() != 0) ? hand_results.pop_front() : '0;
        want  = kv_apply(in_ch.operation, in_ch.key, in_ch.value);
        // typed rows keep their hand-written expectation
        if (hand.typed) want = hand.want;
        pending_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        moved           = 1'b1;
        got.found       = out_ch.found;
        got.value_out   = out_ch.value_out;
        got.entry_count = out_ch.entry_count;
        got.put_dropped = out_ch.put_dropped;
        if (pending_results.size() == 0) begin
          $error("unexpected result: found %0d value_out %h entry_count %0d put_dropped %0d",
                 got.found, got.value_out, got.entry_count, got.put_dropped);
          errors++;
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            errors++;
          end
          if (got.value_out !== want.value_out) begin
            $error("value_out: expected %h, got %h", want.value_out, got.value_out);
            errors++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            errors++;
          end
          if (got.put_dropped !== want.put_dropped) begin
            $error("put_dropped: expected %0d, got %0d", want.put_dropped, got.put_dropped);
            errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("key_value_table verification failed");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

endmodule

// ===== files.f =====
src/kvt_pkg.sv
src/kvt_stream_if.sv
src/kvt_cell.sv
src/key_value_table.sv
src/kvt_checker.sv
bench/key_value_table_test.sv
